/* sv/udec_pkg.sv */
// ----------------------------------------------------------------------------
// udec_pkg
// shared types, status codes and lead-byte helpers for the utf-8 decoder
// ----------------------------------------------------------------------------
package udec_pkg;

    localparam int CP_W      = 21;
    localparam int LEN_W     = 3;
    localparam int ST_W      = 2;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_STRAY = 2'd1;
    localparam logic [ST_W-1:0] ST_ERROR = 2'd2;

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [LEN_W-1:0] seq_length;
        logic [ST_W-1:0]  status;
        logic             run_last;
    } res_t;

    typedef struct packed {
        logic [1:0] n;
        res_t       r0;
        res_t       r1;
    } push_t;

    typedef struct packed {
        logic space2;
        logic nonempty;
    } q_status_t;

    function automatic logic [LEN_W-1:0] lead_size(input logic [7:0] b);
        logic [LEN_W-1:0] n;
        n = 3'd0;
        if (b[7] == 1'b0)
        begin
            n = 3'd1;
        end
        else if (b[7:5] == 3'b110)
        begin
            n = 3'd2;
        end
        else if (b[7:4] == 4'b1110)
        begin
            n = 3'd3;
        end
        else if (b[7:3] == 5'b11110)
        begin
            n = 3'd4;
        end
        return n;
    endfunction

    function automatic res_t make_res(input logic [CP_W-1:0] cp, input logic [LEN_W-1:0] len,
                                      input logic [ST_W-1:0] st);
        res_t r;
        r.code_point = cp;
        r.seq_length = len;
        r.status     = st;
        r.run_last   = 1'b0;
        return r;
    endfunction

endpackage

/* sv/udec_front.sv */
// ----------------------------------------------------------------------------
// udec_front
// takes bytes, tracks the open sequence and pushes zero to two results
// ----------------------------------------------------------------------------
module udec_front
    import udec_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [7:0]      byte_in,
    input  logic            buffer_end,
    input  q_status_t       q_stat,
    output push_t           push
);

    logic [CP_W-1:0]  part_reg, part_next;
    logic [1:0]       rem_reg, rem_next;
    logic [LEN_W-1:0] len_reg, len_next;

    logic             accept;
    logic             contin;
    logic [LEN_W-1:0] lsize;
    logic             lead_emit;
    res_t             lead_res;
    logic [CP_W-1:0]  lead_part;
    logic [CP_W-1:0]  cont_part;
    logic [1:0]       cont_rem;
    push_t            p;

    assign in_stall = ~q_stat.space2;
    assign accept   = in_valid & ~in_stall;
    assign contin   = (byte_in[7:6] == 2'b10);
    assign lsize    = lead_size(byte_in);
    assign cont_part = {part_reg[CP_W-7:0], byte_in[5:0]};
    assign cont_rem  = rem_reg - 2'd1;

    always_comb
    begin
        lead_emit = 1'b1;
        lead_res  = make_res('0, 3'd1, ST_ERROR);
        lead_part = '0;
        if (contin)
        begin
            lead_res = make_res('0, 3'd0, ST_STRAY);
        end
        else
        begin
            case (lsize)
                3'd1:
                begin
                    lead_res = make_res({13'd0, byte_in}, 3'd1, ST_OK);
                end
                3'd2:
                begin
                    lead_part = {16'd0, byte_in[4:0]};
                    lead_emit = buffer_end;
                end
                3'd3:
                begin
                    lead_part = {17'd0, byte_in[3:0]};
                    lead_emit = buffer_end;
                end
                3'd4:
                begin
                    lead_part = {18'd0, byte_in[2:0]};
                    lead_emit = buffer_end;
                end
                default:
                begin
                    lead_res = make_res('0, 3'd1, ST_ERROR);
                end
            endcase
        end
    end

    always_comb
    begin
        p.n  = 2'd0;
        p.r0 = lead_res;
        p.r1 = lead_res;
        part_next = part_reg;
        rem_next  = rem_reg;
        len_next  = len_reg;
        if (rem_reg == 2'd0)
        begin
            if (lead_emit)
            begin
                p.n = 2'd1;
            end
            else
            begin
                part_next = lead_part;
                rem_next  = lsize[1:0] - 2'd1;
                len_next  = lsize;
            end
        end
        else if (contin)
        begin
            part_next = cont_part;
            rem_next  = cont_rem;
            if (cont_rem == 2'd0)
            begin
                p.n  = 2'd1;
                p.r0 = make_res(cont_part, len_reg, ST_OK);
                part_next = '0;
                len_next  = '0;
            end
            else if (buffer_end)
            begin
                p.n  = 2'd1;
                p.r0 = make_res('0, len_reg - {1'b0, cont_rem}, ST_ERROR);
            end
        end
        else
        begin
            p.r0 = make_res('0, len_reg - {1'b0, rem_reg}, ST_ERROR);
            if (lead_emit)
            begin
                p.n = 2'd2;
                part_next = '0;
                rem_next  = '0;
                len_next  = '0;
            end
            else
            begin
                p.n = 2'd1;
                part_next = lead_part;
                rem_next  = lsize[1:0] - 2'd1;
                len_next  = lsize;
            end
        end
        if (buffer_end)
        begin
            part_next = '0;
            rem_next  = '0;
            len_next  = '0;
        end
        if (p.n == 2'd1)
        begin
            p.r0.run_last = 1'b1;
        end
        if (p.n == 2'd2)
        begin
            p.r1.run_last = 1'b1;
        end
        push = p;
        if (!accept)
        begin
            push.n = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_reg <= '0;
            rem_reg  <= '0;
            len_reg  <= '0;
        end
        else if (accept)
        begin
            part_reg <= part_next;
            rem_reg  <= rem_next;
            len_reg  <= len_next;
        end
    end

endmodule

/* sv/udec_queue.sv */
// ----------------------------------------------------------------------------
// udec_queue
// short result queue, two writes and one read per cycle
// ----------------------------------------------------------------------------
module udec_queue
    import udec_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  push_t     push,
    input  logic      pop,
    output res_t      head,
    output q_status_t q_stat
);

    res_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wptr_reg, wptr_next;
    logic [Q_PTR_W-1:0] rptr_reg, rptr_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;
    logic [Q_PTR_W-1:0] wptr_p1;

    assign wptr_p1          = wptr_reg + 1'b1;
    assign head             = mem_reg[rptr_reg];
    assign q_stat.nonempty  = (cnt_reg != '0);
    assign q_stat.space2    = (cnt_reg <= Q_CNT_W'(Q_DEPTH - 2));
    assign wptr_next        = wptr_reg + Q_PTR_W'(push.n);
    assign rptr_next        = rptr_reg + Q_PTR_W'(pop);
    assign cnt_next         = cnt_reg + Q_CNT_W'(push.n) - Q_CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            mem_reg[wptr_reg] <= push.r0;
        end
        if (push.n == 2'd2)
        begin
            mem_reg[wptr_p1] <= push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

/* sv/udec_back.sv */
// ----------------------------------------------------------------------------
// udec_back
// drains the queue into the registered output channel
// ----------------------------------------------------------------------------
module udec_back
    import udec_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  q_status_t q_stat,
    input  res_t      head,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_stall,
    output res_t      out_res
);

    logic valid_reg;
    res_t res_reg;

    assign pop       = q_stat.nonempty & (~valid_reg | ~out_stall);
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= head;
        end
    end

endmodule

/* sv/utf8_stream_decoder_top.sv */
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top
// byte-serial utf-8 decoder with a decoupled result queue
// ----------------------------------------------------------------------------
// One byte is taken per cycle while the queue has room. A byte gives zero,
// one or two result items; a byte that breaks an open sequence gives two
// unless it opens a new one, and the output register delivers one item per
// cycle while out_stall is low. A four-entry queue sits between the decode
// stage and the output register; a byte is taken only while two entries are
// free. A result passes from its queue entry to the output register.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top
    import udec_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        byte_in,
    input  logic              buffer_end,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CP_W-1:0]   code_point,
    output logic [LEN_W-1:0]  seq_length,
    output logic [ST_W-1:0]   status,
    output logic              run_last
);

    push_t     push;
    q_status_t q_stat;
    res_t      head;
    res_t      out_res;
    logic      pop;

    udec_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .byte_in    (byte_in),
        .buffer_end (buffer_end),
        .q_stat     (q_stat),
        .push       (push)
    );

    udec_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .head   (head),
        .q_stat (q_stat)
    );

    udec_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign code_point = out_res.code_point;
    assign seq_length = out_res.seq_length;
    assign status     = out_res.status;
    assign run_last   = out_res.run_last;

endmodule

/* test/utf8_stream_decoder_top_tb.sv */
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top_tb
// self-checking testbench for the byte-serial utf-8 decoder
// ----------------------------------------------------------------------------
// Bytes go in through the valid/stall input channel and result items come
// back through the output channel. A scoreboard class tracks the decoder
// state in parallel, predicts the result items of each accepted byte and
// checks every returned item field by field against the oldest prediction.
// A short directed run covers the code point extremes, stray continuations,
// invalid leads, broken and truncated sequences. It is followed by random
// traffic, mostly well-formed sequences with random payload, mixed with noise
// and cut sequences. Both sides idle at random, one long output hold-off
// fills the decoder, and one pause lets every pending result drain.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import udec_pkg::*;

    localparam int RANDOM_TARGET  = 720;
    localparam int HOLD_AT        = 250;
    localparam int DRAIN_AT       = 500;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 3000;

    localparam logic [8:0] DIRECTED [27] = '{
        9'h000, 9'h07F, 9'h0C2, 9'h0A9, 9'h0DF, 9'h0BF, 9'h0E2, 9'h082, 9'h0AC,
        9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF, 9'h080, 9'h0F8, 9'h0FF, 9'h0E2, 9'h041,
        9'h0F0, 9'h090, 9'h0FF, 9'h1C2, 9'h0E2, 9'h182, 9'h0E2, 9'h1C2, 9'h17F
    };

    class utf8_decode_tracker;
        logic [CP_W-1:0]  acc;
        logic [1:0]       remain;
        logic [LEN_W-1:0] seq_len;
        res_t             pending[$];
        res_t             batch[$];
        int               mismatches;
        int               checked;
        int               status_seen[3];

        function new();
            clear_seq();
            mismatches = 0;
            checked    = 0;
            foreach (status_seen[i])
            begin
                status_seen[i] = 0;
            end
        endfunction

        function void clear_seq();
            acc     = '0;
            remain  = '0;
            seq_len = '0;
        endfunction

        function logic [LEN_W-1:0] lead_bytes(input logic [7:0] b);
            logic [LEN_W-1:0] n;
            casez (b)
                8'b0???????: n = 3'd1;
                8'b110?????: n = 3'd2;
                8'b1110????: n = 3'd3;
                8'b11110???: n = 3'd4;
                default:     n = 3'd0;
            endcase
            return n;
        endfunction

        function void emit(input logic [CP_W-1:0] cp, input logic [LEN_W-1:0] len,
                           input logic [ST_W-1:0] st);
            res_t r;
            r.code_point = cp;
            r.seq_length = len;
            r.status     = st;
            r.run_last   = 1'b0;
            batch.push_back(r);
        endfunction

        function void take_lead(input logic [7:0] b, input logic e);
            logic [LEN_W-1:0] n;
            n = lead_bytes(b);
            if (b[7:6] == 2'b10)
            begin
                emit('0, '0, ST_STRAY);
            end
            else if (n == 3'd0 || (n > 3'd1 && e))
            begin
                emit('0, 3'd1, ST_ERROR);
            end
            else if (n == 3'd1)
            begin
                emit(CP_W'(b), 3'd1, ST_OK);
            end
            else
            begin
                acc     = CP_W'(b & (8'hFF >> (n + 3'd1)));
                remain  = 2'(n - 3'd1);
                seq_len = n;
            end
        endfunction

        function void note_byte(input logic [7:0] b, input logic e);
            res_t r;
            batch.delete();
            if (remain == 2'd0)
            begin
                take_lead(b, e);
            end
            else if (b[7:6] == 2'b10)
            begin
                acc    = (acc << 6) | CP_W'(b[5:0]);
                remain = remain - 2'd1;
                if (remain == 2'd0)
                begin
                    emit(acc, seq_len, ST_OK);
                    clear_seq();
                end
                else if (e)
                begin
                    emit('0, LEN_W'(seq_len - remain), ST_ERROR);
                    clear_seq();
                end
            end
            else
            begin
                emit('0, LEN_W'(seq_len - remain), ST_ERROR);
                clear_seq();
                take_lead(b, e);
            end
            if (e)
            begin
                clear_seq();
            end
            if (batch.size() > 0)
            begin
                r = batch.pop_back();
                r.run_last = 1'b1;
                batch.push_back(r);
            end
            foreach (batch[i])
            begin
                pending.push_back(batch[i]);
            end
        endfunction

        function void check_result(input res_t got);
            res_t want;
            if (pending.size() == 0)
            begin
                $error("result with nothing pending: code_point %h seq_length %0d status %0d",
                       got.code_point, got.seq_length, got.status);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (want.status <= ST_ERROR)
            begin
                status_seen[want.status]++;
            end
            if (got.code_point !== want.code_point)
            begin
                $error("code_point expected %h actual %h", want.code_point, got.code_point);
                mismatches++;
            end
            if (got.seq_length !== want.seq_length)
            begin
                $error("seq_length expected %0d actual %0d", want.seq_length, got.seq_length);
                mismatches++;
            end
            if (got.status !== want.status)
            begin
                $error("status expected %0d actual %0d", want.status, got.status);
                mismatches++;
            end
            if (got.run_last !== want.run_last)
            begin
                $error("run_last expected %0d actual %0d", want.run_last, got.run_last);
                mismatches++;
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [7:0]        byte_in;
    logic              buffer_end;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [CP_W-1:0]   code_point;
    logic [LEN_W-1:0]  seq_length;
    logic [ST_W-1:0]   status;
    logic              run_last;

    utf8_decode_tracker decoder_model = new();

    int bytes_sent    = 0;
    int burst_left    = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int stall_pct     = 0;
    int stall_phase   = 0;
    int idle_cycles   = 0;

    utf8_stream_decoder_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .byte_in    (byte_in),
        .buffer_end (buffer_end),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .code_point (code_point),
        .seq_length (seq_length),
        .status     (status),
        .run_last   (run_last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_byte(input logic [7:0] b, input logic e);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        byte_in    <= b;
        buffer_end <= e;
        do
            @(posedge clk);
        while (in_stall);
        bytes_sent++;
        decoder_model.note_byte(b, e);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (decoder_model.pending.size() > 0);
    endtask

    // receiver stall pattern, with one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = LONG_HOLD;
            out_stall <= 1'b1;
        end
        else
        begin
            if (stall_phase == 0)
            begin
                stall_phase = $urandom_range(20, 80);
                case ($urandom_range(0, 4))
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 20;
                    3:       stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            stall_phase = stall_phase - 1;
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            decoder_model.check_result('{code_point, seq_length, status, run_last});
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles = idle_cycles + 1;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("utf8_stream_decoder_top test failed");
                    $finish;
                end
            end
        end
    end

    initial
    begin : stimulus
        int         kind;
        int         n;
        int         keep;
        logic [7:0] b;
        logic       ends;
        logic [7:0] seq[$];
        bit         hold_done;
        bit         drain_done;

        hold_done  = 1'b0;
        drain_done = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        byte_in    = '0;
        buffer_end = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
        begin
            send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
        end

        while (bytes_sent < RANDOM_TARGET)
        begin
            if (!hold_done && bytes_sent >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_requests++;
            end
            if (!drain_done && bytes_sent >= DRAIN_AT)
            begin
                drain_done = 1'b1;
                drain_results();
            end
            seq.delete();
            kind = $urandom_range(0, 99);
            ends = ($urandom_range(0, 7) == 0);
            if (kind < 70)
            begin
                n    = $urandom_range(1, 4);
                keep = n - 1;
                ends = ($urandom_range(0, 5) == 0);
            end
            else if (kind < 80)
            begin
                n    = $urandom_range(2, 4);
                keep = $urandom_range(0, n - 2);
            end
            if (kind < 80)
            begin
                case (n)
                    1:       b = {1'b0, 7'($urandom)};
                    2:       b = {3'b110, 5'($urandom)};
                    3:       b = {4'b1110, 4'($urandom)};
                    default: b = {5'b11110, 3'($urandom)};
                endcase
                seq.push_back(b);
                repeat (keep) seq.push_back({2'b10, 6'($urandom)});
                // cut sequence: end the buffer early or break it
                if (kind >= 70 && $urandom_range(0, 1) == 0)
                begin
                    b = 8'($urandom);
                    if (b[7:6] == 2'b10)
                    begin
                        b[6] = 1'b1;
                    end
                    seq.push_back(b);
                    ends = ($urandom_range(0, 3) == 0);
                end
                else if (kind >= 70)
                begin
                    ends = 1'b1;
                end
            end
            else if (kind < 90)
            begin
                seq.push_back(8'($urandom));
            end
            else if (kind < 95)
            begin
                seq.push_back({2'b10, 6'($urandom)});
            end
            else
            begin
                seq.push_back({5'b11111, 3'($urandom)});
            end
            foreach (seq[i])
            begin
                send_byte(seq[i], ends && (i == seq.size() - 1));
            end
        end

        in_valid <= 1'b0;
        while (decoder_model.pending.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        $display("sent %0d bytes, checked %0d results (%0d ok, %0d stray, %0d error)",
                 bytes_sent, decoder_model.checked, decoder_model.status_seen[0],
                 decoder_model.status_seen[1], decoder_model.status_seen[2]);
        $display("covered directed corner bytes, random sequences, %s",
                 "a long output hold-off and a full drain");
        if (decoder_model.mismatches == 0 && decoder_model.pending.size() == 0)
        begin
            $display("utf8_stream_decoder_top test passed");
        end
        else
        begin
            $display("utf8_stream_decoder_top test failed");
        end
        $finish;
    end

endmodule
